>>> hw/rtl/psr_pkg.sv
// Shared types, codes and reset values for the polled slot responder.
package psr_pkg;

   localparam int unsigned TIMER_BITS = 16;
   localparam int unsigned GAP_BITS   = 16;
   localparam int unsigned SLOT_BITS  = 8;
   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned OP_BITS    = 2;
   localparam int unsigned CSR_IDX_BITS  = 2;
   localparam int unsigned CSR_DATA_BITS = 16;
   // timer and thresholds are compared at the wider of the two widths
   localparam int unsigned CMP_BITS = (TIMER_BITS > GAP_BITS) ? TIMER_BITS : GAP_BITS;

   localparam logic [OP_BITS-1:0] OP_TICK = 2'd0;
   localparam logic [OP_BITS-1:0] OP_POLL = 2'd1;
   localparam logic [OP_BITS-1:0] OP_LOAD = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CYCLE_GAP = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SILENCE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXPECTED  = 2'd2;

   localparam logic [GAP_BITS-1:0]  RST_CYCLE_GAP = 16'd4000;
   localparam logic [GAP_BITS-1:0]  RST_SILENCE   = 16'd10000;
   localparam logic [SLOT_BITS-1:0] RST_EXPECTED  = 8'd130;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   typedef struct packed {
      logic [SLOT_BITS-1:0]  slot_counter;
      logic [TIMER_BITS-1:0] idle_timer;
      logic                  sync_flag;
      logic                  pending_flag;
      logic [BYTE_BITS-1:0]  pending_byte;
      logic [SLOT_BITS-1:0]  pending_slot;
   } state_type;

   typedef struct packed {
      logic [GAP_BITS-1:0]  cycle_gap_ticks;
      logic [GAP_BITS-1:0]  silence_ticks;
      logic [SLOT_BITS-1:0] expected_slots;
   } cfg_type;

   typedef struct packed {
      logic [OP_BITS-1:0]   opcode;
      logic [BYTE_BITS-1:0] data_byte;
      logic [SLOT_BITS-1:0] slot_address;
   } item_type;

   typedef struct packed {
      logic                 send_valid;
      logic [BYTE_BITS-1:0] send_byte;
      logic [SLOT_BITS-1:0] slot_count;
      logic                 sync_ok;
      logic                 pending;
   } result_type;

endpackage

>>> hw/rtl/psr_step.sv
// Next-state and result logic for one beat of the polled slot responder.
module psr_step (
   input  psr_pkg::state_type  cur,
   input  psr_pkg::cfg_type    cfg,
   input  psr_pkg::item_type   item,
   output psr_pkg::state_type  nxt,
   output psr_pkg::result_type res
);

   logic [psr_pkg::TIMER_BITS-1:0] timer_inc;
   logic [psr_pkg::CMP_BITS-1:0]   timer_cmp;
   logic [psr_pkg::CMP_BITS-1:0]   gap_cmp;
   logic [psr_pkg::CMP_BITS-1:0]   silence_cmp;
   logic                           sent;
   logic [psr_pkg::BYTE_BITS-1:0]  sent_byte;

   // timer saturates rather than wrapping
   assign timer_inc = (cur.idle_timer != psr_pkg::TIMER_MAX) ?
                      cur.idle_timer + 1'b1 : cur.idle_timer;
   assign timer_cmp   = psr_pkg::CMP_BITS'(timer_inc);
   assign gap_cmp     = psr_pkg::CMP_BITS'(cfg.cycle_gap_ticks);
   assign silence_cmp = psr_pkg::CMP_BITS'(cfg.silence_ticks);

   always_comb begin
      nxt       = cur;
      sent      = 1'b0;
      sent_byte = '0;
      case (item.opcode)
         psr_pkg::OP_TICK: begin
            nxt.idle_timer = timer_inc;
            if (cur.slot_counter != '0) begin
               if (timer_cmp > gap_cmp) begin
                  nxt.sync_flag    = (cur.slot_counter == cfg.expected_slots);
                  nxt.slot_counter = '0;
               end
            end else if (cur.sync_flag && (timer_cmp > silence_cmp)) begin
               nxt.sync_flag = 1'b0;
            end
            if (!nxt.sync_flag) begin
               nxt.pending_flag = 1'b0;
            end
         end
         psr_pkg::OP_POLL: begin
            // match against the slot shown before the pulse
            if (cur.pending_flag && (cur.pending_slot == cur.slot_counter)) begin
               sent             = 1'b1;
               sent_byte        = cur.pending_byte;
               nxt.pending_flag = 1'b0;
            end
            nxt.slot_counter = cur.slot_counter + 1'b1;
            nxt.idle_timer   = '0;
         end
         psr_pkg::OP_LOAD: begin
            nxt.pending_byte = item.data_byte;
            nxt.pending_slot = item.slot_address;
            nxt.pending_flag = 1'b1;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   assign res.send_valid = sent;
   assign res.send_byte  = sent_byte;
   assign res.slot_count = nxt.slot_counter;
   assign res.sync_ok    = nxt.sync_flag;
   assign res.pending    = nxt.pending_flag;

endmodule

>>> hw/rtl/polled_slot_responder_top.sv
// Top level of the polled slot responder: state, settings and result register.
//
// Usage:
//   req_ channel carries one event per beat: a time tick, a poll pulse edge
//   or a byte load (data_byte and slot_address used with load only).
//   rsp_ channel returns exactly one result per request beat: send_valid and
//   send_byte when a queued byte goes out in this slot, then the slot count,
//   sync flag and pending flag after the event.
//   csr_ port writes cycle gap, silence limit and expected slot count; write
//   only while no result is outstanding. Index 3 is ignored.
// Timing:
//   The result appears in the cycle after the request beat.
//   One request per cycle is taken while results are drained; the state
//   update is a single pass through psr_step into the state registers.
//   If the receiver stalls, the result is held and req_ready stays high only
//   while the result register is empty or being taken the same cycle.
// Reset:
//   Synchronous active-high reset clears the slot counter, idle timer, sync
//   and pending marks, loads the default settings and empties the result.
module polled_slot_responder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [psr_pkg::OP_BITS-1:0]         req_opcode,
   input  logic [psr_pkg::BYTE_BITS-1:0]       req_data_byte,
   input  logic [psr_pkg::SLOT_BITS-1:0]       req_slot_address,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_send_valid,
   output logic [psr_pkg::BYTE_BITS-1:0]       rsp_send_byte,
   output logic [psr_pkg::SLOT_BITS-1:0]       rsp_slot_count,
   output logic                                rsp_sync_ok,
   output logic                                rsp_pending,
   input  logic                                csr_write_enable,
   input  logic [psr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [psr_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   psr_pkg::state_type  state_ff, state_in;
   psr_pkg::cfg_type    cfg_ff;
   psr_pkg::item_type   item;
   psr_pkg::result_type result_ff, result_in;
   logic                rsp_valid_ff;
   logic                accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign item.opcode       = req_opcode;
   assign item.data_byte    = req_data_byte;
   assign item.slot_address = req_slot_address;

   psr_step u_step (
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .item (item),
      .nxt  (state_in),
      .res  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycle_gap_ticks <= psr_pkg::RST_CYCLE_GAP;
         cfg_ff.silence_ticks   <= psr_pkg::RST_SILENCE;
         cfg_ff.expected_slots  <= psr_pkg::RST_EXPECTED;
      end else if (csr_write_enable) begin
         case (csr_index)
            psr_pkg::CSR_CYCLE_GAP: cfg_ff.cycle_gap_ticks <= csr_write_data;
            psr_pkg::CSR_SILENCE:   cfg_ff.silence_ticks   <= csr_write_data;
            psr_pkg::CSR_EXPECTED:  cfg_ff.expected_slots  <=
                                       csr_write_data[psr_pkg::SLOT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_send_valid = result_ff.send_valid;
   assign rsp_send_byte  = result_ff.send_byte;
   assign rsp_slot_count = result_ff.slot_count;
   assign rsp_sync_ok    = result_ff.sync_ok;
   assign rsp_pending    = result_ff.pending;

endmodule
